>>> src/tcq_pkg.sv
// tcq_pkg: shared types and constants of the timer callout queue
// used by tcq_ctrl, tcq_datapath and timer_callout_queue
package tcq_pkg;

    localparam int SLOT_W  = 4;
    localparam int NSLOTS  = 16;
    localparam int TIME_W  = 64;
    localparam int FUNC_W  = 3;
    localparam int WMIN_W  = 20;
    localparam int WAIT_W  = 27;
    localparam int CFG_IDX_W = 1;

    localparam logic [WMIN_W-1:0] WAIT_MIN_RESET = WMIN_W'(50);
    localparam logic [WAIT_W-1:0] WAIT_MAX_RESET = WAIT_W'(50000);

    localparam logic [FUNC_W-1:0] FUNC_SCHED_AT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHED_AFTER = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MAX = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REMOVE,
        ST_SET,
        ST_INSERT,
        ST_CLEAR,
        ST_TCHECK,
        ST_TEMIT,
        ST_POP,
        ST_FINISH,
        ST_OUT
    } tcq_state_t;

    typedef struct packed {
        logic in_ready;
        logic do_remove;
        logic sched_set;
        logic ins_step;
        logic slot_clear;
        logic pop;
        logic finish;
        logic emit;
        logic emit_last;
    } tcq_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic full;
        logic ins_done;
        logic fire_ok;
        logic have_hold;
        logic pop_periodic;
        logic out_free;
    } tcq_sts_t;

endpackage

>>> src/tcq_ctrl.sv
// tcq_ctrl: sequencer of the timer callout queue
// depends on tcq_pkg; drives tcq_datapath through tcq_cmd_t
module tcq_ctrl import tcq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  tcq_sts_t  sts,
    output tcq_cmd_t  cmd
);

    tcq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.func)
                    FUNC_SCHED_AT, FUNC_SCHED_AFTER, FUNC_CANCEL: state_next = ST_REMOVE;
                    FUNC_QUERY: state_next = ST_FINISH;
                    FUNC_TICK:  state_next = ST_TCHECK;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_REMOVE: begin
                cmd.do_remove = 1'b1;
                state_next = (sts.func == FUNC_CANCEL) ? ST_CLEAR : ST_SET;
            end
            ST_SET: begin
                cmd.sched_set = 1'b1;
                state_next = sts.full ? ST_CLEAR : ST_INSERT;
            end
            ST_INSERT: begin
                cmd.ins_step = 1'b1;
                if (sts.ins_done) begin
                    state_next = (sts.func == FUNC_TICK) ? ST_TCHECK : ST_FINISH;
                end
            end
            ST_CLEAR: begin
                cmd.slot_clear = 1'b1;
                state_next = ST_FINISH;
            end
            ST_TCHECK: begin
                if (sts.fire_ok) begin
                    state_next = sts.have_hold ? ST_TEMIT : ST_POP;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_TEMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                cmd.pop = 1'b1;
                state_next = sts.pop_periodic ? ST_INSERT : ST_TCHECK;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/tcq_datapath.sv
// tcq_datapath: slot tables, ordered list, result hold and output register
// depends on tcq_pkg; commanded by tcq_ctrl
module tcq_datapath import tcq_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int MAX_FIRES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcq_cmd_t              cmd,
    output tcq_sts_t              sts,
    input  logic                  s_tvalid,
    input  logic [199:0]          s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [103:0]          m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WAIT_W-1:0]     cfg_data
);

    // a slot is in the list at most once, so more than NSLOTS cells never fill
    localparam int LDEPTH = (ENTRIES < NSLOTS) ? ENTRIES : NSLOTS;
    localparam int IW = $clog2(LDEPTH);
    localparam int CW = $clog2(LDEPTH + 1);
    localparam int NW = $clog2(MAX_FIRES + 1);

    logic [SLOT_W-1:0] order_reg [LDEPTH];
    logic [SLOT_W-1:0] order_next [LDEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     p_reg;
    logic [NW-1:0]     n_reg;

    logic [TIME_W-1:0] dl_reg  [NSLOTS];
    logic [TIME_W-1:0] per_reg [NSLOTS];
    logic [NSLOTS-1:0] pend_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [SLOT_W-1:0] cs_reg;
    logic [TIME_W-1:0] when_reg, per_in_reg, now_reg, key_reg;

    logic [WMIN_W-1:0] wmin_reg;
    logic [WAIT_W-1:0] wmax_reg;

    logic [SLOT_W-1:0] hold_slot_reg;
    logic              hold_fired_reg, hold_idle_reg;
    logic [TIME_W-1:0] hold_dl_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic              more_reg;

    logic [SLOT_W-1:0] o_slot_reg;
    logic              o_fired_reg, o_idle_reg, o_more_reg, o_last_reg, o_valid_reg;
    logic [TIME_W-1:0] o_dl_reg;
    logic [WAIT_W-1:0] o_wait_reg;

    // single table read port: the scan cell, which is the head while p is zero
    logic [SLOT_W-1:0] rd_slot;
    logic [TIME_W-1:0] rd_dl, rd_per, sum_dl, sched_dl, gap;
    logic              head_due, full, ins_done;
    logic [IW-1:0]     ri;
    logic              ri_found;
    logic [WAIT_W-1:0] wait_calc;

    assign rd_slot = order_reg[p_reg[IW-1:0]];
    assign rd_dl   = dl_reg[rd_slot];
    assign rd_per  = per_reg[rd_slot];
    assign sum_dl  = rd_dl + rd_per;
    assign sched_dl = (func_reg == FUNC_SCHED_AT) ? when_reg : now_reg + when_reg;
    assign head_due = (count_reg != '0) && (rd_dl <= now_reg);
    assign full     = (count_reg == CW'(LDEPTH));
    assign ins_done = !((p_reg < count_reg) && !(key_reg < rd_dl));

    // first list position holding the current slot
    always_comb begin
        ri = '0;
        ri_found = 1'b0;
        for (int j = 0; j < LDEPTH; j++) begin
            if (!ri_found && (CW'(j) < count_reg) && (order_reg[j] == cs_reg)) begin
                ri = IW'(j);
                ri_found = 1'b1;
            end
        end
    end

    // clamped wait
    always_comb begin
        gap = (rd_dl > now_reg) ? rd_dl - now_reg : '0;
        if (count_reg == '0) begin
            wait_calc = wmax_reg;
        end else if (gap <= {{(TIME_W-WMIN_W){1'b0}}, wmin_reg}) begin
            wait_calc = {{(WAIT_W-WMIN_W){1'b0}}, wmin_reg};
        end else if (gap < {{(TIME_W-WAIT_W){1'b0}}, wmax_reg}) begin
            wait_calc = gap[WAIT_W-1:0];
        end else begin
            wait_calc = wmax_reg;
        end
    end

    // list cells: remove shifts down, insert shifts up
    always_comb begin
        for (int j = 0; j < LDEPTH; j++) begin
            order_next[j] = order_reg[j];
        end
        count_next = count_reg;
        if ((cmd.do_remove && pend_reg[cs_reg]) || cmd.pop) begin
            for (int j = 0; j < LDEPTH - 1; j++) begin
                if ((cmd.pop || IW'(j) >= ri) && (CW'(j + 1) < count_reg)) begin
                    order_next[j] = order_reg[j + 1];
                end
            end
            count_next = count_reg - CW'(1);
        end else if (cmd.ins_step && ins_done) begin
            for (int j = 0; j < LDEPTH; j++) begin
                if (CW'(j) == p_reg) begin
                    order_next[j] = cs_reg;
                end else if ((j > 0) && (CW'(j) > p_reg)) begin
                    order_next[j] = order_reg[(j > 0) ? j - 1 : 0];
                end
            end
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < LDEPTH; j++) begin
            order_reg[j] <= order_next[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            p_reg     <= '0;
            n_reg     <= '0;
            pend_reg  <= '0;
            wmin_reg  <= WAIT_MIN_RESET;
            wmax_reg  <= WAIT_MAX_RESET;
            o_valid_reg <= 1'b0;
            for (int k = 0; k < NSLOTS; k++) begin
                dl_reg[k]  <= '0;
                per_reg[k] <= '0;
            end
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WAIT_MIN: wmin_reg <= cfg_data[WMIN_W-1:0];
                    CFG_WAIT_MAX: wmax_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.in_ready && s_tvalid) begin
                p_reg <= '0;
                n_reg <= '0;
            end
            if (cmd.ins_step) begin
                if (ins_done) begin
                    p_reg <= '0;
                    pend_reg[cs_reg] <= 1'b1;
                end else begin
                    p_reg <= p_reg + CW'(1);
                end
            end
            if (cmd.sched_set) begin
                dl_reg[cs_reg]  <= sched_dl;
                per_reg[cs_reg] <= per_in_reg;
            end
            if (cmd.slot_clear) begin
                pend_reg[cs_reg] <= 1'b0;
                dl_reg[cs_reg]   <= '0;
                per_reg[cs_reg]  <= '0;
            end
            if (cmd.pop) begin
                n_reg <= n_reg + NW'(1);
                if (rd_per != '0) begin
                    dl_reg[rd_slot] <= sum_dl;
                end else begin
                    dl_reg[rd_slot]   <= '0;
                    pend_reg[rd_slot] <= 1'b0;
                end
            end
            if (cmd.emit || cmd.emit_last) begin
                o_valid_reg <= 1'b1;
            end else if (m_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_ready && s_tvalid) begin
            func_reg   <= s_tuser;
            cs_reg     <= s_tdata[3:0];
            when_reg   <= s_tdata[67:4];
            per_in_reg <= s_tdata[131:68];
            now_reg    <= s_tdata[195:132];
            hold_slot_reg  <= '0;
            hold_fired_reg <= 1'b0;
            hold_idle_reg  <= 1'b0;
            hold_dl_reg    <= '0;
        end
        if (cmd.sched_set) begin
            key_reg <= sched_dl;
        end
        if (cmd.pop) begin
            cs_reg         <= rd_slot;
            key_reg        <= sum_dl;
            hold_slot_reg  <= rd_slot;
            hold_fired_reg <= 1'b1;
            hold_idle_reg  <= (rd_per == '0);
            hold_dl_reg    <= rd_dl;
        end
        if (cmd.finish) begin
            wait_reg <= wait_calc;
            more_reg <= (n_reg == NW'(MAX_FIRES)) && head_due;
            if (func_reg != FUNC_TICK) begin
                hold_slot_reg  <= cs_reg;
                hold_fired_reg <= 1'b0;
                hold_idle_reg  <= !pend_reg[cs_reg];
                hold_dl_reg    <= '0;
            end
        end
        if (cmd.emit || cmd.emit_last) begin
            o_slot_reg  <= hold_slot_reg;
            o_fired_reg <= hold_fired_reg;
            o_idle_reg  <= hold_idle_reg;
            o_dl_reg    <= hold_dl_reg;
            o_wait_reg  <= cmd.emit_last ? wait_reg : '0;
            o_more_reg  <= cmd.emit_last && more_reg;
            o_last_reg  <= cmd.emit_last;
        end
    end

    assign sts.func         = func_reg;
    assign sts.full         = full;
    assign sts.ins_done     = ins_done;
    assign sts.fire_ok      = (n_reg < NW'(MAX_FIRES)) && head_due;
    assign sts.have_hold    = (n_reg != '0);
    assign sts.pop_periodic = (rd_per != '0);
    assign sts.out_free     = !o_valid_reg || m_tready;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {7'd0, o_more_reg, o_wait_reg, o_dl_reg, o_idle_reg, o_slot_reg};
    assign m_tuser  = o_fired_reg;
    assign m_tlast  = o_last_reg;

endmodule

>>> src/timer_callout_queue.sv
// timer_callout_queue: top level of the deadline-ordered timer slot queue
// depends on tcq_pkg, tcq_ctrl and tcq_datapath
//
// Sixteen timer slots, each with a 64-bit deadline, a 64-bit period and a
// pending mark, kept in a list sorted by deadline (ties keep arrival order).
// One request at a time: a request is taken, worked on, and its last result is
// loaded into the output register before the next request is taken. A schedule
// removes the slot, sets its deadline and scans the list for the insert point
// (the insert scan compares one entry per cycle), or is dropped on a full
// list; cancel removes and clears the slot; query reports the slot; a tick
// pops due heads up to MAX_FIRES and re-inserts each periodic one; an unknown
// function gives no result. Results leave through an output register, so a
// stalled master side holds the sequencer only when a further result is due.
// No clearing pass is needed after reset.
module timer_callout_queue import tcq_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int MAX_FIRES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot[3:0], when_us[67:4], period_us[131:68], now_us[195:132], zero pad
    input  logic [199:0]         s_tdata,
    // func[2:0]
    input  logic [FUNC_W-1:0]    s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_slot[3:0], idle_slot[4], fired_deadline[68:5], next_wait_us[95:69],
    // more_pending[96], zero pad
    output logic [103:0]         m_tdata,
    // fired[0]
    output logic                 m_tuser,
    output logic                 m_tlast,
    // configuration writes: 0 wait_min_us, 1 wait_max_us
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WAIT_W-1:0]    cfg_data
);

    tcq_cmd_t cmd;
    tcq_sts_t sts;

    // request taken only while the sequencer is waiting for one
    assign s_tready = cmd.in_ready;

    tcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcq_datapath #(
        .ENTRIES   (ENTRIES),
        .MAX_FIRES (MAX_FIRES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
